// ===== hw/rtl/ledenc_pkg.sv =====
// ============================================================================
// ledenc_pkg: shared definitions for the LED strip pulse code encoder
// Constants, command and configuration types, and the pixel count clamp.
// ============================================================================
`default_nettype none

package ledenc_pkg;

   // Strip geometry
   localparam int MAX_PIXELS     = 256;
   localparam int PIX_IDX_W      = 8;
   localparam int COUNT_W        = 9;
   localparam int COLOR_W        = 8;
   localparam int PIXEL_W        = 3 * COLOR_W;
   localparam int BITS_PER_PIXEL = PIXEL_W;
   localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);
   localparam int CODE_W         = 16;

   // Command queue between front and back
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_CODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_CODE   = 2'd2;

   localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = '0;
   localparam logic [CODE_W-1:0]  ONE_CODE_RESET    = 16'd58;
   localparam logic [CODE_W-1:0]  ZERO_CODE_RESET   = 16'd29;

   // Request function codes
   localparam logic FUNC_SET_PIXEL = 1'b0;
   localparam logic FUNC_RENDER    = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_RENDER,
      OP_CLEAR_CURSOR
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [PIX_IDX_W-1:0]   index;
      logic [PIXEL_W-1:0]     color;   // green, red, blue
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] eff_count;
      logic [CODE_W-1:0]  one_code;
      logic [CODE_W-1:0]  zero_code;
   } cfg_type;

   // Clamp the programmed pixel count to the store capacity
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] cap;
      cap = COUNT_W'(MAX_PIXELS);
      return (count > cap) ? cap : count;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ledenc_front.sv =====
// ============================================================================
// ledenc_front: request intake and classification
// Accepts request transactions, drops out-of-range pixel writes and turns the
// rest into commands for the back end.
// ============================================================================
`default_nettype none

module ledenc_front (
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_func,
   input  wire logic [ledenc_pkg::PIX_IDX_W-1:0]   req_pixel_index,
   input  wire logic [ledenc_pkg::COLOR_W-1:0]     req_red,
   input  wire logic [ledenc_pkg::COLOR_W-1:0]     req_green,
   input  wire logic [ledenc_pkg::COLOR_W-1:0]     req_blue,
   input  wire ledenc_pkg::cfg_type                cfg,
   output logic                                    push_valid,
   output ledenc_pkg::cmd_type                     push_cmd,
   input  wire logic                               push_ready
);

   logic keep;

   // Take a transaction whenever the queue has room
   assign req_ready = push_ready;

   // Classify the request
   always_comb begin
      push_cmd.index = req_pixel_index;
      push_cmd.color = {req_green, req_red, req_blue};
      keep           = 1'b1;
      if (req_func == ledenc_pkg::FUNC_SET_PIXEL) begin
         push_cmd.op = ledenc_pkg::OP_WRITE;
         keep        = ({1'b0, req_pixel_index} < cfg.eff_count);
      end else if (cfg.eff_count == '0) begin
         push_cmd.op = ledenc_pkg::OP_CLEAR_CURSOR;
      end else begin
         push_cmd.op = ledenc_pkg::OP_RENDER;
      end
   end

   // Drop writes beyond the strip, forward everything else
   assign push_valid = req_valid && push_ready && keep;

endmodule

`default_nettype wire

// ===== hw/rtl/ledenc_cmd_fifo.sv =====
// ============================================================================
// ledenc_cmd_fifo: command queue
// Short register queue that decouples request intake from bit emission.
// ============================================================================
`default_nettype none

module ledenc_cmd_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire ledenc_pkg::cmd_type  push_cmd,
   output logic                      push_ready,
   output logic                      pop_valid,
   output ledenc_pkg::cmd_type       pop_cmd,
   input  wire logic                 pop_ready
);

   ledenc_pkg::cmd_type                    entries_ff [ledenc_pkg::CMD_DEPTH];
   logic [ledenc_pkg::CMD_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ledenc_pkg::CMD_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ledenc_pkg::CMD_CNT_W-1:0]       count_ff, count_in;
   logic                                   push, pop;

   assign push_ready = (count_ff < ledenc_pkg::CMD_CNT_W'(ledenc_pkg::CMD_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ledenc_pkg::CMD_PTR_W'(ledenc_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ledenc_pkg::CMD_PTR_W'(ledenc_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold command payloads
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> count_ff < ledenc_pkg::CMD_CNT_W'(ledenc_pkg::CMD_DEPTH))
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("command popped from an empty queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue occupancy did not track a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ledenc_back.sv =====
// ============================================================================
// ledenc_back: pixel store and bit serializer
// Executes queued commands: writes pixels, and renders the pixel under the
// frame cursor as 24 pulse codes in green, red, blue order, MSB first.
// ============================================================================
`default_nettype none

module ledenc_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ledenc_pkg::cfg_type              cfg,
   input  wire logic                             cmd_valid,
   input  wire ledenc_pkg::cmd_type              cmd,
   output logic                                  cmd_ready,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ledenc_pkg::CODE_W-1:0]         rsp_pulse_code,
   output logic                                  rsp_frame_end
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_SHIFT
   } state_type;

   localparam logic [ledenc_pkg::BIT_CNT_W-1:0] LAST_BIT =
      ledenc_pkg::BIT_CNT_W'(ledenc_pkg::BITS_PER_PIXEL - 1);

   // Pixel store with per-entry valid bits; an unwritten entry reads as zero
   logic [ledenc_pkg::PIXEL_W-1:0]       pix_mem [ledenc_pkg::MAX_PIXELS];
   logic [ledenc_pkg::MAX_PIXELS-1:0]    valid_ff, valid_in;
   logic [ledenc_pkg::PIXEL_W-1:0]       rd_data_ff;
   logic                                 rd_hit_ff;

   state_type                            state_ff, state_in;
   logic [ledenc_pkg::PIX_IDX_W-1:0]     cursor_ff, cursor_in;
   logic [ledenc_pkg::PIXEL_W-1:0]       shift_ff, shift_in;
   logic [ledenc_pkg::BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic                                 last_pixel_ff, last_pixel_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [ledenc_pkg::CODE_W-1:0]        rsp_code_ff, rsp_code_in;
   logic                                 rsp_end_ff, rsp_end_in;

   logic                                 cmd_pop, mem_write, out_free, load_bit;
   logic [ledenc_pkg::PIX_IDX_W-1:0]     cur_fix;
   logic                                 cur_last;

   assign cmd_ready = (state_ff == S_IDLE);
   assign cmd_pop   = cmd_valid && cmd_ready;
   assign mem_write = cmd_pop && (cmd.op == ledenc_pkg::OP_WRITE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_bit  = (state_ff == S_SHIFT) && out_free;

   // Wrap a stale cursor and flag the last pixel of the frame
   assign cur_fix  = ({1'b0, cursor_ff} >= cfg.eff_count) ? '0 : cursor_ff;
   assign cur_last = (({1'b0, cur_fix} + 1'b1) == cfg.eff_count);

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      cursor_in     = cursor_ff;
      shift_in      = shift_ff;
      bit_cnt_in    = bit_cnt_ff;
      last_pixel_in = last_pixel_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_end_in    = rsp_end_ff;

      // Drop the held result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               case (cmd.op)
                  ledenc_pkg::OP_WRITE: begin
                     valid_in[cmd.index] = 1'b1;
                  end
                  ledenc_pkg::OP_RENDER: begin
                     last_pixel_in = cur_last;
                     cursor_in     = cur_last ? '0 : cur_fix + 1'b1;
                     state_in      = S_FETCH;
                  end
                  ledenc_pkg::OP_CLEAR_CURSOR: begin
                     cursor_in = '0;
                  end
                  default: begin
                     cursor_in = cursor_ff;
                  end
               endcase
            end
         end
         S_FETCH: begin
            shift_in   = rd_hit_ff ? rd_data_ff : '0;
            bit_cnt_in = '0;
            state_in   = S_SHIFT;
         end
         S_SHIFT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = shift_ff[ledenc_pkg::PIXEL_W-1] ? cfg.one_code : cfg.zero_code;
               rsp_end_in   = last_pixel_ff && (bit_cnt_ff == LAST_BIT);
               shift_in     = {shift_ff[ledenc_pkg::PIXEL_W-2:0], 1'b0};
               bit_cnt_in   = bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == LAST_BIT) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         cursor_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         shift_ff      <= '0;
         bit_cnt_ff    <= '0;
         last_pixel_ff <= 1'b0;
         rsp_code_ff   <= '0;
         rsp_end_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cursor_ff     <= cursor_in;
         rsp_valid_ff  <= rsp_valid_in;
         shift_ff      <= shift_in;
         bit_cnt_ff    <= bit_cnt_in;
         last_pixel_ff <= last_pixel_in;
         rsp_code_ff   <= rsp_code_in;
         rsp_end_ff    <= rsp_end_in;
      end
   end

   // Pixel store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_write) begin
         pix_mem[cmd.index] <= cmd.color;
      end
      rd_data_ff <= pix_mem[cur_fix];
      rd_hit_ff  <= valid_ff[cur_fix];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pulse_code = rsp_code_ff;
   assign rsp_frame_end  = rsp_end_ff;

`ifndef NO_ASSERTIONS
   a_fetch_to_shift: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |=> state_ff == S_SHIFT)
      else $error("pixel fetch did not start the serializer");

   a_frame_end_cursor: assert property (@(posedge clock) disable iff (reset)
      (load_bit && last_pixel_ff && bit_cnt_ff == LAST_BIT) |-> cursor_ff == '0)
      else $error("frame ended without the cursor wrapping");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && !out_free) |=> $stable(shift_ff) && $stable(bit_cnt_ff))
      else $error("serializer advanced while output was stalled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/led_strip_pulse_code_encoder.sv =====
// ============================================================================
// led_strip_pulse_code_encoder: GRB pulse code encoder for an LED strip
// Stores RGB pixels and renders them as per-bit pulse compare values.
//
//   channel  prefix  direction  transaction
//   request  req_    in         set pixel or render next pixel
//   result   rsp_    out        one pulse code, frame end flag
//   config   csr_    in         register write, no wait
//
// A render transaction yields 24 codes, one per cycle while rsp_ready holds;
// it occupies the serializer through a store read, a load and 24 shifts.
// A pixel write is handled in the back end's idle state. No clearing pass:
// per-pixel valid bits make the store read as zero after reset. A 2-entry
// command queue lets requests be taken while the serializer is stalled.
// ============================================================================
`default_nettype none

module led_strip_pulse_code_encoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_func,
   input  wire logic [ledenc_pkg::PIX_IDX_W-1:0]    req_pixel_index,
   input  wire logic [ledenc_pkg::COLOR_W-1:0]      req_red,
   input  wire logic [ledenc_pkg::COLOR_W-1:0]      req_green,
   input  wire logic [ledenc_pkg::COLOR_W-1:0]      req_blue,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ledenc_pkg::CODE_W-1:0]            rsp_pulse_code,
   output logic                                     rsp_frame_end,
   input  wire logic                                csr_wr_en,
   input  wire logic [ledenc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ledenc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [ledenc_pkg::COUNT_W-1:0]  pixel_count_ff;
   logic [ledenc_pkg::CODE_W-1:0]   one_code_ff;
   logic [ledenc_pkg::CODE_W-1:0]   zero_code_ff;
   ledenc_pkg::cfg_type             cfg;

   logic                            push_valid, push_ready;
   ledenc_pkg::cmd_type             push_cmd;
   logic                            pop_valid, pop_ready;
   ledenc_pkg::cmd_type             pop_cmd;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= ledenc_pkg::PIXEL_COUNT_RESET;
         one_code_ff    <= ledenc_pkg::ONE_CODE_RESET;
         zero_code_ff   <= ledenc_pkg::ZERO_CODE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ledenc_pkg::REG_PIXEL_COUNT: pixel_count_ff <= csr_wdata[ledenc_pkg::COUNT_W-1:0];
            ledenc_pkg::REG_ONE_CODE:    one_code_ff    <= csr_wdata[ledenc_pkg::CODE_W-1:0];
            ledenc_pkg::REG_ZERO_CODE:   zero_code_ff   <= csr_wdata[ledenc_pkg::CODE_W-1:0];
            default: begin
               pixel_count_ff <= pixel_count_ff;
            end
         endcase
      end
   end

   assign cfg.eff_count = ledenc_pkg::clamp_count(pixel_count_ff);
   assign cfg.one_code  = one_code_ff;
   assign cfg.zero_code = zero_code_ff;

   ledenc_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .cfg             (cfg),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd),
      .push_ready      (push_ready)
   );

   ledenc_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   ledenc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd_valid      (pop_valid),
      .cmd            (pop_cmd),
      .cmd_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pulse_code (rsp_pulse_code),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

`default_nettype wire

// ===== tb/sv/led_strip_pulse_code_encoder_tb.sv =====
// ============================================================================
// LED strip pulse code encoder testbench
// Drives pixel writes and render requests through the request channel,
// reprograms the strip between phases, and checks every pulse code and
// frame end flag against a cycle-free model of the GRB bit encoding.
// ============================================================================

module led_strip_pulse_code_encoder_tb;

   import ledenc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int IDLE_PERCENT    = 26;

   typedef struct packed {
      logic [CODE_W-1:0] pulse_code;
      logic              frame_end;
   } pulse_item_type;

   // Model of the pixel store and frame cursor; holds the pulse codes still owed
   class pulse_code_scoreboard;
      logic [PIXEL_W-1:0] pixel_mem [MAX_PIXELS];
      int unsigned        cursor;
      logic [COUNT_W-1:0] pixel_count;
      logic [CODE_W-1:0]  one_code;
      logic [CODE_W-1:0]  zero_code;
      pulse_item_type     expected_pulses [$];
      int unsigned        mismatches;

      function new();
         foreach (pixel_mem[i]) pixel_mem[i] = '0;
         cursor      = 0;
         pixel_count = PIXEL_COUNT_RESET;
         one_code    = ONE_CODE_RESET;
         zero_code   = ZERO_CODE_RESET;
         mismatches  = 0;
      endfunction

      function int unsigned effective_count();
         return (pixel_count > MAX_PIXELS) ? MAX_PIXELS : pixel_count;
      endfunction

      function int unsigned pending();
         return expected_pulses.size();
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_PIXEL_COUNT: pixel_count = data[COUNT_W-1:0];
            REG_ONE_CODE:    one_code    = data[CODE_W-1:0];
            REG_ZERO_CODE:   zero_code   = data[CODE_W-1:0];
            default: ;
         endcase
      endfunction

      // Store a pixel, or queue the 24 codes of the pixel under the cursor
      function void note_request(logic func, logic [PIX_IDX_W-1:0] idx,
                                 logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                 logic [COLOR_W-1:0] b);
         int unsigned        eff;
         logic [PIXEL_W-1:0] px;
         bit                 last_pixel;
         pulse_item_type     item;
         eff = effective_count();
         if (func == FUNC_SET_PIXEL) begin
            if (idx < eff) pixel_mem[idx] = {g, r, b};
            return;
         end
         // empty strip: nothing to send, park the cursor
         if (eff == 0) begin
            cursor = 0;
            return;
         end
         // count was lowered under the cursor: restart the frame
         if (cursor >= eff) cursor = 0;
         px         = pixel_mem[cursor];
         last_pixel = (cursor + 1 == eff);
         for (int k = 0; k < BITS_PER_PIXEL; k++) begin
            item.pulse_code = px[PIXEL_W-1-k] ? one_code : zero_code;
            item.frame_end  = last_pixel && (k == BITS_PER_PIXEL - 1);
            expected_pulses.push_back(item);
         end
         cursor = last_pixel ? 0 : cursor + 1;
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      // Compare one accepted result against the oldest owed code
      task check_pulse(logic [CODE_W-1:0] code, logic frame_end);
         pulse_item_type want;
         if (expected_pulses.size() == 0) begin
            report_mismatch($sformatf("unexpected pulse code %0d frame_end %0b",
                                      code, frame_end));
            return;
         end
         want = expected_pulses.pop_front();
         if (code !== want.pulse_code)
            report_mismatch($sformatf("pulse_code %0d, want %0d", code, want.pulse_code));
         if (frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %0b, want %0b", frame_end, want.frame_end));
      endtask
   endclass

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic                  req_func        = FUNC_SET_PIXEL;
   logic [PIX_IDX_W-1:0]  req_pixel_index = '0;
   logic [COLOR_W-1:0]    req_red         = '0;
   logic [COLOR_W-1:0]    req_green       = '0;
   logic [COLOR_W-1:0]    req_blue        = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [CODE_W-1:0]     rsp_pulse_code;
   logic                  rsp_frame_end;
   logic                  csr_wr_en       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   bit                    throttle        = 1'b1;
   int unsigned           idle_cycles     = 0;
   pulse_code_scoreboard  sb              = new();

   led_strip_pulse_code_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pulse_code  (rsp_pulse_code),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_ready <= !(throttle && ($urandom_range(0, 99) < IDLE_PERCENT));
   end

   // Sample every handshake at the rising edge; watch for a hung block
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.note_config(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_request(req_func, req_pixel_index, req_red, req_green, req_blue);
         if (rsp_valid && rsp_ready) sb.check_pulse(rsp_pulse_code, rsp_frame_end);
         if (csr_wr_en || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Offer one request transaction and hold it until accepted
   task automatic send_request(logic func, logic [PIX_IDX_W-1:0] idx,
                               logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                               logic [COLOR_W-1:0] b);
      while (throttle && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_pixel_index <= idx;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop the request and let the block drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all three registers back to back
   task automatic program_strip(logic [CSR_DATA_W-1:0] count,
                                logic [CSR_DATA_W-1:0] one, logic [CSR_DATA_W-1:0] zero);
      csr_wr_en <= 1'b1;
      csr_index <= REG_PIXEL_COUNT;
      csr_wdata <= count;
      @(negedge clock);
      csr_index <= REG_ONE_CODE;
      csr_wdata <= one;
      @(negedge clock);
      csr_index <= REG_ZERO_CODE;
      csr_wdata <= zero;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [COLOR_W-1:0] pick_intensity();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return COLOR_W'($urandom());
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CODE_W'($urandom());
      endcase
   endfunction

   // Mostly in-range writes and renders, with writes past the strip mixed in
   task automatic random_items(int unsigned n);
      int unsigned          eff;
      logic                 func;
      logic [PIX_IDX_W-1:0] idx;
      eff = sb.effective_count();
      for (int i = 0; i < n; i++) begin
         func = ($urandom_range(0, 99) < 55) ? FUNC_RENDER : FUNC_SET_PIXEL;
         if (eff > 0 && $urandom_range(0, 99) < 85)
            idx = PIX_IDX_W'($urandom_range(0, eff - 1));
         else
            idx = PIX_IDX_W'($urandom_range(0, 255));
         send_request(func, idx, pick_intensity(), pick_intensity(), pick_intensity());
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] count;

      // hold reset, then release on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty strip straight out of reset: render sends nothing, writes drop
      send_request(FUNC_RENDER, 8'd0, 8'h00, 8'h00, 8'h00);
      send_request(FUNC_SET_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_request(FUNC_RENDER, 8'd0, 8'h00, 8'h00, 8'h00);
      wait_idle();

      // four pixels, one primary each plus white, extreme codes
      program_strip(16'd4, 16'hFFFF, 16'h0000);
      send_request(FUNC_SET_PIXEL, 8'd0, 8'hFF, 8'h00, 8'h00);
      send_request(FUNC_SET_PIXEL, 8'd1, 8'h00, 8'hFF, 8'h00);
      send_request(FUNC_SET_PIXEL, 8'd2, 8'h00, 8'h00, 8'hFF);
      send_request(FUNC_SET_PIXEL, 8'd3, 8'hFF, 8'hFF, 8'hFF);
      // writes past the strip are dropped
      send_request(FUNC_SET_PIXEL, 8'd4, 8'hAA, 8'h55, 8'hAA);
      send_request(FUNC_SET_PIXEL, 8'd255, 8'h55, 8'hAA, 8'h55);
      // full frame, wrap, then park the cursor on pixel 3
      repeat (7) send_request(FUNC_RENDER, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_idle();

      // shrink under the cursor; store keeps its contents
      program_strip(16'd2, 16'h0000, 16'hFFFF);
      repeat (2) send_request(FUNC_RENDER, 8'd0, 8'h00, 8'h00, 8'h00);
      wait_idle();

      // count above capacity saturates; top index becomes writable
      program_strip(16'd511, 16'd58, 16'd29);
      send_request(FUNC_SET_PIXEL, 8'd255, 8'h0F, 8'hF0, 8'h3C);
      send_request(FUNC_RENDER, 8'd0, 8'h00, 8'h00, 8'h00);
      wait_idle();

      // random phases, each under its own strip setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       count = 16'd1;
            1:       count = 16'd3;
            2:       count = 16'd0;
            3:       count = 16'hFE02;
            4:       count = 16'd256;
            5:       count = 16'd511;
            default: count = 16'($urandom_range(1, 12));
         endcase
         program_strip(count, pick_code(), pick_code());
         throttle = (p != 3);
         random_items(ITEMS_PER_PHASE);
         wait_idle();
      end
      throttle = 1'b1;

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
